// File: rtl/core/m64sh_pkg.sv
// ----------------------------------------------------------------------------
// m64sh_pkg
// Shared types and constants for the MurmurHash64A segment hasher.
// ----------------------------------------------------------------------------
`default_nettype none

package m64sh_pkg;

   localparam int unsigned LENGTH_WIDTH_DEF = 32;

   localparam logic [63:0] MUR_M      = 64'hc6a4a7935bd1e995;
   localparam int unsigned MUR_R      = 47;
   localparam logic [63:0] COMB_MAGIC = 64'h0000_0000_9e37_79b9;

   localparam logic [1:0] MODE_START   = 2'd0;
   localparam logic [1:0] MODE_BYTE    = 2'd1;
   localparam logic [1:0] MODE_COMBINE = 2'd2;
   localparam logic [1:0] MODE_CLEAR   = 2'd3;

   typedef struct packed {
      logic [1:0]  mode;
      logic [31:0] seg_length;
      logic [7:0]  data_byte;
      logic [63:0] combine_value;
   } req_type;

   typedef struct packed {
      logic [63:0] digest;
      logic [63:0] seed_after;
   } rsp_type;

endpackage

`default_nettype wire

// File: rtl/core/murmur64a_segment_hasher.sv
// ----------------------------------------------------------------------------
// murmur64a_segment_hasher
// MurmurHash64A over byte segments, each digest folded into a running seed.
//
// Items enter on req_ (valid/ready) and results leave on rsp_ (valid/ready).
// One 32x32 multiplier and one 64-bit adder are shared under a sequencer;
// every 64-bit product by the Murmur constant takes three passes (S_MUL0 to S_MUL2).
// req_ready is high only while the sequencer is idle.
//   start segment : one product, plus finalize when the length is zero
//   data byte     : taken in the idle state; a byte that completes an 8-byte block
//                   takes three products; the tail mix adds one product
//   finalize      : one product, then the fold steps to the result register
//   combine value : the fold steps S_FOLD1 to S_FOLD3 to the result register
//   clear seed    : done in the idle state
// Results sit in an output register; new items are taken while it waits.
// If a new result is ready before the old one is taken, the sequencer holds
// in its last fold step until rsp_ready frees the register.
// Reset (synchronous, active high) clears the seed, closes any segment and
// drops a pending result.
// ----------------------------------------------------------------------------
`default_nettype none

module murmur64a_segment_hasher #(
   parameter int unsigned LENGTH_WIDTH = m64sh_pkg::LENGTH_WIDTH_DEF
) (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 req_valid,
   output logic                req_ready,
   input  m64sh_pkg::req_type  req_data,
   output logic                rsp_valid,
   input  wire                 rsp_ready,
   output m64sh_pkg::rsp_type  rsp_data
);

   localparam logic [3:0] S_IDLE       = 4'd0;
   localparam logic [3:0] S_MUL0       = 4'd1;
   localparam logic [3:0] S_MUL1       = 4'd2;
   localparam logic [3:0] S_MUL2       = 4'd3;
   localparam logic [3:0] S_START_DONE = 4'd4;
   localparam logic [3:0] S_BLK_K1     = 4'd5;
   localparam logic [3:0] S_BLK_K2     = 4'd6;
   localparam logic [3:0] S_BLK_DONE   = 4'd7;
   localparam logic [3:0] S_TAIL_DONE  = 4'd8;
   localparam logic [3:0] S_FIN_START  = 4'd9;
   localparam logic [3:0] S_FIN_DONE   = 4'd10;
   localparam logic [3:0] S_FOLD1      = 4'd11;
   localparam logic [3:0] S_FOLD2      = 4'd12;
   localparam logic [3:0] S_FOLD3      = 4'd13;

   localparam logic [63:0] LenMask = (LENGTH_WIDTH >= 64) ? {64{1'b1}} :
                                     ((64'd1 << LENGTH_WIDTH) - 64'd1);

   logic [3:0]              state_ff, state_in;
   logic [3:0]              ret_ff, ret_in;
   logic [63:0]             x_ff, x_in;
   logic [63:0]             acc_ff, acc_in;
   logic [63:0]             mix_ff, mix_in;
   logic [63:0]             accum_ff, accum_in;
   logic [2:0]              pos_ff, pos_in;
   logic [LENGTH_WIDTH-1:0] left_ff, left_in;
   logic                    open_ff, open_in;
   logic [63:0]             seed_ff, seed_in;
   logic [63:0]             digest_ff, digest_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   m64sh_pkg::rsp_type      rsp_data_ff, rsp_data_in;

   logic [31:0]             mul_a, mul_b;
   logic [63:0]             mul_p;
   logic [63:0]             add_a, add_b, add_s;

   logic                    accept;
   logic [63:0]             len_ext;
   logic [3:0]              pos_n;
   logic [3:0]              room;
   logic                    tail;
   logic [63:0]             byte_ext;
   logic [63:0]             accum_n;
   logic [LENGTH_WIDTH-1:0] left_n;
   logic                    slot_free;

   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign slot_free = !rsp_valid_ff || rsp_ready;

   // shared multiplier: one 32x32 partial product per cycle
   assign mul_a = (state_ff == S_MUL2) ? x_ff[63:32] : x_ff[31:0];
   assign mul_b = (state_ff == S_MUL1) ? m64sh_pkg::MUR_M[63:32] : m64sh_pkg::MUR_M[31:0];
   assign mul_p = 64'(mul_a) * 64'(mul_b);

   // shared adder
   always_comb begin
      add_a = acc_ff;
      add_b = {mul_p[31:0], 32'd0};
      case (state_ff)
         S_MUL0: begin
            add_a = 64'd0;
            add_b = mul_p;
         end
         S_FOLD1: begin
            add_a = digest_ff;
            add_b = m64sh_pkg::COMB_MAGIC;
         end
         S_FOLD2: add_b = {seed_ff[57:0], 6'd0};
         S_FOLD3: add_b = {2'd0, seed_ff[63:2]};
         default: ;
      endcase
   end
   assign add_s = add_a + add_b;

   assign len_ext  = {32'd0, req_data.seg_length} & LenMask;
   assign pos_n    = {1'b0, pos_ff} + 4'd1;
   assign room     = 4'd8 - {1'b0, pos_ff};
   assign tail     = left_ff < {{(LENGTH_WIDTH-4){1'b0}}, room};
   assign byte_ext = (tail && req_data.data_byte[7]) ? {{56{1'b1}}, req_data.data_byte}
                                                     : {56'd0, req_data.data_byte};
   assign accum_n  = accum_ff | (byte_ext << {pos_ff, 3'd0});
   assign left_n   = left_ff - {{(LENGTH_WIDTH-1){1'b0}}, 1'b1};

   always_comb begin
      state_in     = state_ff;
      ret_in       = ret_ff;
      x_in         = x_ff;
      acc_in       = acc_ff;
      mix_in       = mix_ff;
      accum_in     = accum_ff;
      pos_in       = pos_ff;
      left_in      = left_ff;
      open_in      = open_ff;
      seed_in      = seed_ff;
      digest_in    = digest_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_ready ? 1'b0 : rsp_valid_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (req_data.mode)
                  m64sh_pkg::MODE_START: begin
                     x_in     = len_ext;
                     accum_in = 64'd0;
                     pos_in   = 3'd0;
                     left_in  = len_ext[LENGTH_WIDTH-1:0];
                     open_in  = |len_ext;
                     ret_in   = S_START_DONE;
                     state_in = S_MUL0;
                  end
                  m64sh_pkg::MODE_BYTE: begin
                     if (open_ff) begin
                        left_in = left_n;
                        if (!tail && pos_n[3]) begin
                           x_in     = accum_n;
                           accum_in = 64'd0;
                           pos_in   = 3'd0;
                           ret_in   = S_BLK_K1;
                           state_in = S_MUL0;
                        end else begin
                           accum_in = accum_n;
                           pos_in   = pos_n[2:0];
                           if (left_n == '0) begin
                              open_in = 1'b0;
                              if (pos_n[2:0] != 3'd0) begin
                                 x_in     = mix_ff ^ accum_n;
                                 ret_in   = S_TAIL_DONE;
                                 state_in = S_MUL0;
                              end else begin
                                 state_in = S_FIN_START;
                              end
                           end
                        end
                     end
                  end
                  m64sh_pkg::MODE_COMBINE: begin
                     digest_in = req_data.combine_value;
                     state_in  = S_FOLD1;
                  end
                  m64sh_pkg::MODE_CLEAR: seed_in = 64'd0;
                  default: ;
               endcase
            end
         end
         S_MUL0: begin
            acc_in   = add_s;
            state_in = S_MUL1;
         end
         S_MUL1: begin
            acc_in   = add_s;
            state_in = S_MUL2;
         end
         S_MUL2: begin
            acc_in   = add_s;
            state_in = ret_ff;
         end
         S_START_DONE: begin
            mix_in   = acc_ff;
            state_in = open_ff ? S_IDLE : S_FIN_START;
         end
         S_BLK_K1: begin
            x_in     = acc_ff ^ (acc_ff >> m64sh_pkg::MUR_R);
            ret_in   = S_BLK_K2;
            state_in = S_MUL0;
         end
         S_BLK_K2: begin
            x_in     = mix_ff ^ acc_ff;
            ret_in   = S_BLK_DONE;
            state_in = S_MUL0;
         end
         S_BLK_DONE: begin
            mix_in = acc_ff;
            if (left_ff == '0) begin
               open_in  = 1'b0;
               state_in = S_FIN_START;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_TAIL_DONE: begin
            mix_in   = acc_ff;
            state_in = S_FIN_START;
         end
         S_FIN_START: begin
            x_in     = mix_ff ^ (mix_ff >> m64sh_pkg::MUR_R);
            ret_in   = S_FIN_DONE;
            state_in = S_MUL0;
         end
         S_FIN_DONE: begin
            digest_in = acc_ff ^ (acc_ff >> m64sh_pkg::MUR_R);
            state_in  = S_FOLD1;
         end
         S_FOLD1: begin
            acc_in   = add_s;
            state_in = S_FOLD2;
         end
         S_FOLD2: begin
            acc_in   = add_s;
            state_in = S_FOLD3;
         end
         S_FOLD3: begin
            // hold until the output register is free
            if (slot_free) begin
               seed_in                = seed_ff ^ add_s;
               rsp_data_in.digest     = digest_ff;
               rsp_data_in.seed_after = seed_ff ^ add_s;
               rsp_valid_in           = 1'b1;
               state_in               = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         accum_ff     <= 64'd0;
         pos_ff       <= 3'd0;
         left_ff      <= '0;
         open_ff      <= 1'b0;
         seed_ff      <= 64'd0;
         mix_ff       <= 64'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         accum_ff     <= accum_in;
         pos_ff       <= pos_in;
         left_ff      <= left_in;
         open_ff      <= open_in;
         seed_ff      <= seed_in;
         mix_ff       <= mix_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ret_ff      <= ret_in;
      x_ff        <= x_in;
      acc_ff      <= acc_in;
      digest_ff   <= digest_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_clear_seed: assert property (@(posedge clock) disable iff (reset)
      (accept && req_data.mode == m64sh_pkg::MODE_CLEAR) |=> (seed_ff == 64'd0))
      else $error("seed not cleared");

   a_open_has_bytes: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE && open_ff) |-> (left_ff != '0))
      else $error("open segment with no bytes left");

   a_rsp_from_fold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_in && !(rsp_valid_ff && !rsp_ready)) |-> (state_ff == S_FOLD3))
      else $error("result loaded outside final fold");

   a_mul_advance: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MUL0) |=> (state_ff == S_MUL1))
      else $error("multiply sequence broken");

endmodule

`default_nettype wire

// File: tb/murmur64a_segment_hasher_check.sv
// ----------------------------------------------------------------------------
// murmur64a_segment_hasher_check
// Watches both channels of the segment hasher, predicts every digest and
// running seed from the accepted request items, and compares each accepted
// response item field by field with the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module murmur64a_segment_hasher_check (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 req_valid,
   input  wire                 req_ready,
   input  m64sh_pkg::req_type  req_data,
   input  wire                 rsp_valid,
   input  wire                 rsp_ready,
   input  m64sh_pkg::rsp_type  rsp_data,
   output int                  errors,
   output int                  due_count
);
   timeunit 1ns;
   timeprecision 1ps;

   logic [63:0] mix_state   = '0;
   logic [63:0] block_accum = '0;
   logic [63:0] seed        = '0;
   logic [31:0] bytes_left  = '0;
   logic        seg_open    = 1'b0;
   int unsigned fill_pos    = 0;

   m64sh_pkg::rsp_type hashes_due[$];

   function automatic logic [63:0] seed_fold(logic [63:0] s, logic [63:0] v);
      return s ^ (v + m64sh_pkg::COMB_MAGIC + (s << 6) + (s >> 2));
   endfunction

   function automatic logic [63:0] avalanche(logic [63:0] h);
      logic [63:0] x;
      x = h ^ (h >> m64sh_pkg::MUR_R);
      x = x * m64sh_pkg::MUR_M;
      return x ^ (x >> m64sh_pkg::MUR_R);
   endfunction

   task automatic drop_segment();
      mix_state   = '0;
      block_accum = '0;
      fill_pos    = 0;
      bytes_left  = '0;
      seg_open    = 1'b0;
   endtask

   task automatic close_segment();
      logic [63:0] d;
      d    = avalanche(mix_state);
      seed = seed_fold(seed, d);
      hashes_due.push_back('{digest: d, seed_after: seed});
      drop_segment();
   endtask

   task automatic absorb_byte(logic [7:0] data);
      logic [63:0] b;
      logic [63:0] k;
      logic        tail;
      b    = {56'b0, data};
      tail = (bytes_left < 32'(8 - fill_pos));
      if (tail && b[7]) begin
         b |= 64'hFFFF_FFFF_FFFF_FF00;
      end
      block_accum |= b << (8 * fill_pos);
      fill_pos++;
      bytes_left--;
      if (!tail && fill_pos == 8) begin
         k = block_accum * m64sh_pkg::MUR_M;
         k ^= k >> m64sh_pkg::MUR_R;
         k = k * m64sh_pkg::MUR_M;
         mix_state ^= k;
         mix_state = mix_state * m64sh_pkg::MUR_M;
         block_accum = '0;
         fill_pos = 0;
      end
      fill_pos = fill_pos & 7;
      if (bytes_left == 0) begin
         if (fill_pos != 0) begin
            mix_state ^= block_accum;
            mix_state = mix_state * m64sh_pkg::MUR_M;
         end
         close_segment();
      end
   endtask

   task automatic absorb_item(m64sh_pkg::req_type it);
      case (it.mode)
         m64sh_pkg::MODE_START: begin
            drop_segment();
            mix_state = {32'b0, it.seg_length} * m64sh_pkg::MUR_M;
            if (it.seg_length == 0) begin
               close_segment();
            end else begin
               bytes_left = it.seg_length;
               seg_open   = 1'b1;
            end
         end
         m64sh_pkg::MODE_BYTE: begin
            if (seg_open) begin
               absorb_byte(it.data_byte);
            end
         end
         m64sh_pkg::MODE_COMBINE: begin
            seed = seed_fold(seed, it.combine_value);
            hashes_due.push_back('{digest: it.combine_value, seed_after: seed});
         end
         default: begin
            seed = '0;
         end
      endcase
   endtask

   task automatic compare_result(m64sh_pkg::rsp_type got);
      m64sh_pkg::rsp_type want;
      if (hashes_due.size() == 0) begin
         errors++;
         $display("%0t: unexpected result, expected none actual %h %h",
                  $time, got.digest, got.seed_after);
      end else begin
         want = hashes_due.pop_front();
         if (got.digest !== want.digest) begin
            errors++;
            $display("%0t: digest mismatch, expected %h actual %h",
                     $time, want.digest, got.digest);
         end
         if (got.seed_after !== want.seed_after) begin
            errors++;
            $display("%0t: seed_after mismatch, expected %h actual %h",
                     $time, want.seed_after, got.seed_after);
         end
      end
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            compare_result(rsp_data);
         end
         if (req_valid && req_ready) begin
            absorb_item(req_data);
         end
      end
      due_count = hashes_due.size();
   end

endmodule

// File: tb/murmur64a_segment_hasher_test.sv
// ----------------------------------------------------------------------------
// murmur64a_segment_hasher_test
// Drives the segment hasher with directed cases and random segments, seed
// combines and clears under varying idle patterns on both channels, including
// a long response stall and a full drain, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module murmur64a_segment_hasher_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 400_000;
   localparam int STALL_CYCLES = 500;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   m64sh_pkg::req_type req_data = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   m64sh_pkg::rsp_type rsp_data;
   int                 errors;
   int                 due_count;

   int      send_idle = 6;
   int      recv_idle = 53;
   int      items_sent = 0;
   int      cycles = 0;
   int      hold_left = 0;
   logic    stall_toggle = 1'b0;
   logic    stall_seen = 1'b0;

   always #4 clock = ~clock;

   murmur64a_segment_hasher dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   murmur64a_segment_hasher_check checker_inst (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .errors    (errors),
      .due_count (due_count)
   );

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("murmur64a_segment_hasher_test NOT OK");
         $finish;
      end
   end

   always @(negedge clock) begin
      if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else if (stall_toggle != stall_seen) begin
         stall_seen <= stall_toggle;
         hold_left  <= STALL_CYCLES;
         rsp_ready  <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle);
      end
   end

   function automatic m64sh_pkg::req_type noise();
      m64sh_pkg::req_type x;
      x.mode          = 2'($urandom);
      x.seg_length    = $urandom;
      x.data_byte     = 8'($urandom);
      x.combine_value = {$urandom, $urandom};
      return x;
   endfunction

   function automatic m64sh_pkg::req_type item_of(logic [1:0] m, logic [31:0] len,
                                                  logic [7:0] b, logic [63:0] v);
      m64sh_pkg::req_type x;
      x.mode          = m;
      x.seg_length    = len;
      x.data_byte     = b;
      x.combine_value = v;
      return x;
   endfunction

   task automatic send_item(m64sh_pkg::req_type it);
      @(negedge clock);
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= it;
      do @(posedge clock); while (!req_ready);
      items_sent++;
   endtask

   task automatic send_bytes(logic [7:0] bytes[$]);
      foreach (bytes[i]) begin
         send_item(item_of(m64sh_pkg::MODE_BYTE, 32'd0, bytes[i], 64'd0));
      end
   endtask

   task automatic drain(int extra);
      @(negedge clock);
      req_valid <= 1'b0;
      while (due_count != 0) begin
         @(negedge clock);
      end
      repeat (extra) @(negedge clock);
   endtask

   task automatic random_segment();
      int unsigned        r;
      int unsigned        len;
      int unsigned        cut;
      m64sh_pkg::req_type it;
      r = $urandom_range(99);
      if (r < 8) begin
         len = 0;
      end else if (r < 80) begin
         len = $urandom_range(16, 1);
      end else if (r < 95) begin
         len = $urandom_range(40, 17);
      end else begin
         len = $urandom_range(80, 41);
      end
      cut = ($urandom_range(9) == 0) ? $urandom_range(len) : len;
      it = noise();
      it.mode = m64sh_pkg::MODE_START;
      it.seg_length = len;
      send_item(it);
      for (int i = 0; i < cut; i++) begin
         if ($urandom_range(29) == 0) begin
            it = noise();
            it.mode = ($urandom_range(1) == 0) ? m64sh_pkg::MODE_COMBINE
                                               : m64sh_pkg::MODE_CLEAR;
            send_item(it);
         end
         it = noise();
         it.mode = m64sh_pkg::MODE_BYTE;
         send_item(it);
      end
   endtask

   task automatic random_until(int target);
      int unsigned        r;
      int unsigned        n;
      m64sh_pkg::req_type it;
      while (items_sent < target) begin
         r = $urandom_range(99);
         it = noise();
         if (r < 65) begin
            random_segment();
         end else if (r < 77) begin
            it.mode = m64sh_pkg::MODE_COMBINE;
            send_item(it);
         end else if (r < 84) begin
            it.mode = m64sh_pkg::MODE_CLEAR;
            send_item(it);
         end else if (r < 90) begin
            it.mode = m64sh_pkg::MODE_BYTE;
            send_item(it);
         end else begin
            it.mode = m64sh_pkg::MODE_START;
            send_item(it);
            n = $urandom_range(3);
            repeat (n) begin
               it = noise();
               it.mode = m64sh_pkg::MODE_BYTE;
               send_item(it);
            end
         end
      end
   endtask

   initial begin
      repeat (2) @(negedge clock);
      reset <= 1'b0;

      send_item(item_of(m64sh_pkg::MODE_CLEAR, 32'd0, 8'd0, 64'd0));
      send_item(item_of(m64sh_pkg::MODE_START, 32'd0, 8'd0, 64'd0));
      send_item(item_of(m64sh_pkg::MODE_COMBINE, 32'd0, 8'd0, 64'hFFFF_FFFF_FFFF_FFFF));
      send_item(item_of(m64sh_pkg::MODE_START, 32'd8, 8'd0, 64'd0));
      send_bytes('{8'h00, 8'hFF, 8'h80, 8'h7F, 8'h01, 8'hFE, 8'h55, 8'hAA});
      send_item(item_of(m64sh_pkg::MODE_BYTE, 32'd0, 8'h12, 64'd0));
      send_item(item_of(m64sh_pkg::MODE_START, 32'd3, 8'd0, 64'd0));
      send_bytes('{8'h80, 8'h7F, 8'hFF});
      send_item(item_of(m64sh_pkg::MODE_START, 32'd2, 8'd0, 64'd0));
      send_bytes('{8'h33});
      send_item(item_of(m64sh_pkg::MODE_START, 32'd1, 8'd0, 64'd0));
      send_bytes('{8'hC0});
      send_item(item_of(m64sh_pkg::MODE_START, 32'd2, 8'd0, 64'd0));
      send_bytes('{8'h81});
      send_item(item_of(m64sh_pkg::MODE_COMBINE, 32'd0, 8'd0, 64'h0123_4567_89AB_CDEF));
      send_item(item_of(m64sh_pkg::MODE_CLEAR, 32'd0, 8'd0, 64'd0));
      send_bytes('{8'hF0});
      send_item(item_of(m64sh_pkg::MODE_START, 32'hFFFF_FFFF, 8'd0, 64'd0));
      send_bytes('{8'hFF});
      send_item(item_of(m64sh_pkg::MODE_START, 32'd0, 8'd0, 64'd0));

      random_until(600);
      drain(40);

      send_idle = 53;
      recv_idle = 6;
      random_until(1150);

      send_idle = 0;
      recv_idle = 0;
      stall_toggle = ~stall_toggle;
      random_until(1700);
      drain(60);

      if (errors == 0 && due_count == 0) begin
         $display("murmur64a_segment_hasher_test OK");
      end else begin
         $display("murmur64a_segment_hasher_test NOT OK");
      end
      $finish;
   end

endmodule

// File: murmur64a_segment_hasher.f
rtl/core/m64sh_pkg.sv
rtl/core/murmur64a_segment_hasher.sv
tb/murmur64a_segment_hasher_check.sv
tb/murmur64a_segment_hasher_test.sv
